[src/skt_pkg.sv]
`default_nettype none

package skt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_RANGE     = 2'd3
  } status_t;

  // per-cycle operation broadcast to every cell
  typedef struct packed {
    logic ins;
    logic rem;
  } cell_ctl_t;

  localparam int unsigned KEY_PORT_W   = 32;
  localparam int unsigned POS_W        = 4;
  localparam int unsigned COUNT_PORT_W = 5;
  localparam int unsigned POS_SPAN     = 16;

endpackage

`default_nettype wire

[src/skt_cell.sv]
`default_nettype none

module skt_cell #(
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                   clk,
  input  skt_pkg::cell_ctl_t    ctl,
  input  wire  [KEY_WIDTH-1:0]  new_key,
  input  wire                   valid,
  input  wire                   left_lt,
  input  wire  [KEY_WIDTH-1:0]  left_key,
  input  wire  [KEY_WIDTH-1:0]  right_key,
  output logic [KEY_WIDTH-1:0]  key_q,
  output logic                  lt,
  output logic                  eq
);
  import skt_pkg::*;

  logic [KEY_WIDTH-1:0] key_r;
  logic [KEY_WIDTH-1:0] key_nxt;

  assign lt    = valid && (key_r < new_key);
  assign eq    = valid && (key_r == new_key);
  assign key_q = key_r;

  // cells below the insert/remove point hold; the rest shift one place
  always_comb begin
    key_nxt = key_r;
    if (ctl.ins && !lt) begin
      key_nxt = left_lt ? new_key : left_key;
    end else if (ctl.rem && !lt) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

[src/sorted_key_table_top.sv]
`default_nettype none

// Result: out_valid strobes in the cycle after the command transfer.
// Throughput: one command per cycle; busy stays low, every command completes
//   in a single pass through the compare/shift cell row.
// Reset (rst_n low, synchronous): table emptied, count zero, no result pending.
// The receiver cannot stall: out_valid is a one-cycle strobe.
module sorted_key_table_top #(
  parameter int unsigned DEPTH     = 16,
  parameter int unsigned KEY_WIDTH = 32
) (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire                              start,
  output logic                             busy,
  input  wire  [1:0]                       in_command,
  input  wire  [skt_pkg::KEY_PORT_W-1:0]   in_key,
  input  wire  [skt_pkg::POS_W-1:0]        in_position,
  output logic                             out_valid,
  output logic [skt_pkg::KEY_PORT_W-1:0]   out_read_key,
  output logic [1:0]                       out_status,
  output logic [skt_pkg::COUNT_PORT_W-1:0] out_entry_count
);
  import skt_pkg::*;

  localparam int unsigned CW  = $clog2(DEPTH + 1);
  localparam int unsigned RDN = (DEPTH < POS_SPAN) ? DEPTH : POS_SPAN;

  logic                 in_fire;
  logic [KEY_WIDTH-1:0] key_w;
  logic [KEY_WIDTH-1:0] cell_key [DEPTH];
  logic [DEPTH-1:0]     cell_lt;
  logic [DEPTH-1:0]     cell_eq;
  logic [DEPTH-1:0]     cell_valid;
  cell_ctl_t            ctl;
  logic                 full;
  logic                 found;

  logic [CW-1:0]               count_r;
  logic [CW-1:0]               count_nxt;
  logic                        out_valid_r;
  logic [KEY_PORT_W-1:0]       read_key_r;
  logic [KEY_PORT_W-1:0]       read_key_nxt;
  status_t                     status_r;
  status_t                     status_nxt;
  logic [COUNT_PORT_W-1:0]     entry_count_r;

  assign busy    = 1'b0;
  assign in_fire = start && !busy;
  assign key_w   = KEY_WIDTH'(in_key);
  assign full    = (count_r == CW'(DEPTH));
  assign found   = |cell_eq;

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      cell_valid[i] = (CW'(i) < count_r);
    end
  end

  always_comb begin
    ctl = '0;
    if (in_fire) begin
      unique case (cmd_t'(in_command))
        CMD_INSERT: ctl.ins = !full;
        CMD_REMOVE: ctl.rem = found;
        default:    ctl = '0;
      endcase
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                 left_lt;
    logic [KEY_WIDTH-1:0] left_key;
    logic [KEY_WIDTH-1:0] right_key;

    if (g == 0) begin : g_head
      assign left_lt  = 1'b1;
      assign left_key = key_w;
    end else begin : g_mid
      assign left_lt  = cell_lt[g-1];
      assign left_key = cell_key[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_key = cell_key[g];
    end else begin : g_body
      assign right_key = cell_key[g+1];
    end

    skt_cell #(
      .KEY_WIDTH (KEY_WIDTH)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_key   (key_w),
      .valid     (cell_valid[g]),
      .left_lt   (left_lt),
      .left_key  (left_key),
      .right_key (right_key),
      .key_q     (cell_key[g]),
      .lt        (cell_lt[g]),
      .eq        (cell_eq[g])
    );
  end

  // result and count update
  always_comb begin
    count_nxt    = count_r;
    status_nxt   = ST_OK;
    read_key_nxt = '0;
    unique case (cmd_t'(in_command))
      CMD_INSERT: begin
        if (full) status_nxt = ST_FULL;
        else      count_nxt  = count_r + CW'(1);
      end
      CMD_REMOVE: begin
        if (found) count_nxt  = count_r - CW'(1);
        else       status_nxt = ST_NOT_FOUND;
      end
      CMD_READ: begin
        if (CW'(in_position) >= count_r || 32'(in_position) >= DEPTH) begin
          status_nxt = ST_RANGE;
        end else begin
          // position is 4 bits wide, so only the first cells are reachable
          for (int i = 0; i < RDN; i++) begin
            if (in_position == POS_W'(i)) read_key_nxt = KEY_PORT_W'(cell_key[i]);
          end
        end
      end
      default: begin
        status_nxt = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= in_fire;
      if (in_fire) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      read_key_r    <= read_key_nxt;
      status_r      <= status_nxt;
      entry_count_r <= COUNT_PORT_W'(count_nxt);
    end
  end

  assign out_valid       = out_valid_r;
  assign out_read_key    = read_key_r;
  assign out_status      = status_r;
  assign out_entry_count = entry_count_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("held count exceeds table depth");

  a_strobe_follows_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_fire))
    else $error("result strobe without a preceding command transfer");

  // stored keys ascending means the less-than flags form a prefix
  a_lt_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((cell_lt >> 1) & ~cell_lt) == '0)
    else $error("cell row out of order");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == ST_FULL) |-> (count_r == CW'(DEPTH)))
    else $error("full status with table not full");

endmodule

`default_nettype wire
